// ----- hw/rtl/crcfv_pkg.sv -----
// ----------------------------------------------------------------------------
// crcfv_pkg
// Shared types, status codes and the CRC-16/CCITT-FALSE byte update for the
// CRC-16 frame validator.
// ----------------------------------------------------------------------------
package crcfv_pkg;

  // Frame layout and CRC constants
  localparam int unsigned POS_W       = 9;
  localparam int unsigned HDR_BYTES   = 4;
  localparam int unsigned MIN_BYTES   = 6;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_TOP     = 16'h8000;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Configuration port
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;
  localparam logic [7:0]  MAGIC_RESET = 8'h00;

  // Verdict codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TOO_SHORT = 2'd1;
  localparam logic [1:0] STATUS_BAD_MAGIC = 2'd2;
  localparam logic [1:0] STATUS_BAD_CRC   = 2'd3;

  // One received byte with its buffer marks
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_buffer;
    logic       last_of_buffer;
  } frame_in_t;

  // One result: forwarded payload byte and/or verdict
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_payload;
    logic       is_verdict;
    logic [1:0] status;
    logic [7:0] frame_msg_id;
    logic [7:0] frame_seq;
    logic [7:0] payload_length;
  } frame_out_t;

  // Fold one byte into the CRC, MSB first, all eight bit steps unrolled
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/crcfv_apb_regs.sv -----
// ----------------------------------------------------------------------------
// crcfv_apb_regs
// APB-style register port holding the expected magic byte.
// ----------------------------------------------------------------------------
module crcfv_apb_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crcfv_pkg::PADDR_W-1:0] paddr,
  input  logic [crcfv_pkg::PDATA_W-1:0] pwdata,
  output logic [crcfv_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  output logic [7:0]                    magic_value
);
  import crcfv_pkg::*;

  logic wr_en;

  // Single register at offset 0
  assign wr_en  = psel && penable && pwrite && (paddr == '0);
  assign pready = 1'b1;
  assign prdata = {{(PDATA_W-8){1'b0}}, magic_value};

  // Hold the magic byte, update on a completed write
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_value <= MAGIC_RESET;
    end else if (wr_en) begin
      magic_value <= pwdata[7:0];
    end
  end

endmodule

// ----- hw/rtl/crcfv_frame_engine.sv -----
// ----------------------------------------------------------------------------
// crcfv_frame_engine
// Frame parse state and its single-pass next-state logic: header capture,
// byte-wide CRC update, payload forwarding and verdict generation.
// ----------------------------------------------------------------------------
module crcfv_frame_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  crcfv_pkg::frame_in_t  item_q,
  input  logic [7:0]            magic_value,
  output logic                  has_result,
  output crcfv_pkg::frame_out_t result_next
);
  import crcfv_pkg::*;

  // Parse state
  logic [POS_W-1:0] byte_position;
  logic [15:0]      running_crc;
  logic             magic_mismatch;
  logic [7:0]       header_length;
  logic [7:0]       header_msg_id;
  logic [7:0]       header_seq;
  logic [7:0]       crc_low_byte;
  logic             frame_finished;

  logic [POS_W-1:0] byte_position_next;
  logic [15:0]      running_crc_next;
  logic             magic_mismatch_next;
  logic [7:0]       header_length_next;
  logic [7:0]       header_msg_id_next;
  logic [7:0]       header_seq_next;
  logic [7:0]       crc_low_byte_next;
  logic             frame_finished_next;

  // Working values after an optional start-of-buffer clear
  logic [POS_W-1:0] pos;
  logic [15:0]      crc_cur;
  logic             mism_cur;
  logic [7:0]       len_cur;
  logic             fin_cur;
  logic [POS_W-1:0] crc_lo_pos;
  logic [15:0]      crc_upd;
  logic [15:0]      crc_got;
  logic             payload;
  logic             verdict;
  logic [1:0]       status;

  assign crc_upd = crc_add_byte(crc_cur, item_q.data_byte);
  assign crc_got = {item_q.data_byte, crc_low_byte_next};

  always_comb begin
    // Start from current state, or from a cleared frame on a first mark
    pos                 = item_q.first_of_buffer ? '0 : byte_position;
    crc_cur             = item_q.first_of_buffer ? CRC_INIT : running_crc;
    mism_cur            = item_q.first_of_buffer ? 1'b0 : magic_mismatch;
    len_cur             = item_q.first_of_buffer ? 8'h00 : header_length;
    fin_cur             = item_q.first_of_buffer ? 1'b0 : frame_finished;
    header_msg_id_next  = item_q.first_of_buffer ? 8'h00 : header_msg_id;
    header_seq_next     = item_q.first_of_buffer ? 8'h00 : header_seq;
    crc_low_byte_next   = item_q.first_of_buffer ? 8'h00 : crc_low_byte;
    byte_position_next  = pos;
    running_crc_next    = crc_cur;
    magic_mismatch_next = mism_cur;
    header_length_next  = len_cur;
    frame_finished_next = fin_cur;
    crc_lo_pos          = {1'b0, len_cur} + POS_W'(HDR_BYTES);
    payload             = 1'b0;
    verdict             = 1'b0;
    status              = STATUS_OK;

    if (!fin_cur) begin
      // Place the byte within the frame
      if (pos < POS_W'(HDR_BYTES)) begin
        case (pos[1:0])
          2'd0:    magic_mismatch_next = (item_q.data_byte != magic_value);
          2'd1:    header_msg_id_next  = item_q.data_byte;
          2'd2:    header_length_next  = item_q.data_byte;
          default: header_seq_next     = item_q.data_byte;
        endcase
        running_crc_next = crc_upd;
      end else if (pos < crc_lo_pos) begin
        running_crc_next = crc_upd;
        payload          = !mism_cur;
      end else if (pos == crc_lo_pos) begin
        crc_low_byte_next = item_q.data_byte;
      end else begin
        verdict = 1'b1;
        if (mism_cur) begin
          status = STATUS_BAD_MAGIC;
        end else if (crc_got == crc_cur) begin
          status = STATUS_OK;
        end else begin
          status = STATUS_BAD_CRC;
        end
      end

      // Close an incomplete frame at buffer end
      if (!verdict && item_q.last_of_buffer) begin
        verdict = 1'b1;
        if (pos < POS_W'(MIN_BYTES - 1)) begin
          status = STATUS_TOO_SHORT;
        end else if (mism_cur) begin
          status = STATUS_BAD_MAGIC;
        end else begin
          status = STATUS_TOO_SHORT;
        end
      end

      // Advance the saturating position
      byte_position_next  = (pos == POS_MAX) ? POS_MAX : pos + 1'b1;
      frame_finished_next = verdict;
    end
  end

  // Result seen by the output register
  assign has_result                 = payload || verdict;
  assign result_next.out_byte       = payload ? item_q.data_byte : 8'h00;
  assign result_next.is_payload     = payload;
  assign result_next.is_verdict     = verdict;
  assign result_next.status         = verdict ? status : STATUS_OK;
  assign result_next.frame_msg_id   = header_msg_id_next;
  assign result_next.frame_seq      = header_seq_next;
  assign result_next.payload_length = header_length_next;

  // Commit state when the held item is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      running_crc    <= CRC_INIT;
      magic_mismatch <= 1'b0;
      header_length  <= 8'h00;
      header_msg_id  <= 8'h00;
      header_seq     <= 8'h00;
      crc_low_byte   <= 8'h00;
      frame_finished <= 1'b0;
    end else if (step) begin
      byte_position  <= byte_position_next;
      running_crc    <= running_crc_next;
      magic_mismatch <= magic_mismatch_next;
      header_length  <= header_length_next;
      header_msg_id  <= header_msg_id_next;
      header_seq     <= header_seq_next;
      crc_low_byte   <= crc_low_byte_next;
      frame_finished <= frame_finished_next;
    end
  end

endmodule

// ----- hw/rtl/crc16_frame_validator_top.sv -----
// ----------------------------------------------------------------------------
// crc16_frame_validator_top
// Streaming frame checker: forwards payload bytes and gives one verdict per
// frame, checked with CRC-16/CCITT-FALSE.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while not stalled; the byte is held in an input
// register, then the parse state, header capture and an eight-step unrolled
// CRC byte update run in one pass into the result register. A byte that
// produces no result still passes through the input register. Input stalls
// only while a result waits in the output register and the input register is
// full. The magic byte is set over the register port at offset 0.
module crc16_frame_validator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crcfv_pkg::PADDR_W-1:0] paddr,
  input  logic [crcfv_pkg::PDATA_W-1:0] pwdata,
  output logic [crcfv_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  crcfv_pkg::frame_in_t          item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output crcfv_pkg::frame_out_t         result
);
  import crcfv_pkg::*;

  logic       [7:0] magic_value;
  frame_in_t        item_q;
  logic             item_q_valid;
  logic             advance;
  logic             has_result;
  frame_out_t       result_next;

  crcfv_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .magic_value (magic_value)
  );

  crcfv_frame_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item_q      (item_q),
    .magic_value (magic_value),
    .has_result  (has_result),
    .result_next (result_next)
  );

  // Process the held item when the output register can take its result
  assign advance    = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      item_q_valid <= 1'b1;
    end else if (advance) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= has_result;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      result <= result_next;
    end
  end

endmodule

// ----- tb/sv/crc16_frame_validator_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc16_frame_validator_top_tb
// Self-checking bench for the CRC-16 frame validator. Byte buffers go in over
// a valid/ready channel and a local parser model predicts every forwarded
// payload byte and frame verdict. A monitor compares each result against the
// oldest prediction. The magic byte is set over the register port between
// phases, and both channels idle at random.
// ----------------------------------------------------------------------------
module crc16_frame_validator_top_tb;
  import crcfv_pkg::*;

  typedef logic [7:0] octet_q_t[$];

  localparam logic [PADDR_W-1:0] MAGIC_ADDR = '0;
  // Results pass through the input and result registers; leave ample margin
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS  = 460;
  localparam int unsigned PHASES        = 4;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               item_valid;
  logic               item_ready;
  frame_in_t          item;
  logic               result_valid;
  logic               result_ready;
  frame_out_t         result;

  // Parser model state
  logic [7:0]       magic_cfg;
  logic [POS_W-1:0] parse_pos;
  logic [15:0]      crc_acc;
  logic             magic_bad;
  logic [7:0]       hdr_len;
  logic [7:0]       hdr_id;
  logic [7:0]       hdr_seq;
  logic [7:0]       crc_lo;
  logic             frame_done;

  frame_out_t pending_results[$];
  int         mismatches;
  int         items_sent;
  int         quiet_cycles;
  logic       steady;

  crc16_frame_validator_top dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // CRC-16/CCITT-FALSE, one message bit at a time
  function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  task automatic clear_frame();
    parse_pos  = '0;
    crc_acc    = CRC_INIT;
    magic_bad  = 1'b0;
    hdr_len    = 8'h00;
    hdr_id     = 8'h00;
    hdr_seq    = 8'h00;
    crc_lo     = 8'h00;
    frame_done = 1'b0;
  endtask

  // Advance the parser by one accepted byte and queue the result it causes
  task automatic predict_byte(input frame_in_t it);
    int         p;
    int         plen;
    logic       pay;
    logic       verd;
    logic [1:0] st;
    frame_out_t r;
    pay  = 1'b0;
    verd = 1'b0;
    st   = STATUS_OK;
    if (it.first_of_buffer) begin
      clear_frame();
    end
    if (!frame_done) begin
      p    = parse_pos;
      plen = hdr_len;
      if (p < HDR_BYTES) begin
        case (p)
          0: begin
            magic_bad = (it.data_byte != magic_cfg);
          end
          1: begin
            hdr_id = it.data_byte;
          end
          2: begin
            hdr_len = it.data_byte;
          end
          default: begin
            hdr_seq = it.data_byte;
          end
        endcase
        crc_acc = crc_fold(crc_acc, it.data_byte);
      end else if (p < plen + HDR_BYTES) begin
        crc_acc = crc_fold(crc_acc, it.data_byte);
        pay     = !magic_bad;
      end else if (p == plen + HDR_BYTES) begin
        crc_lo = it.data_byte;
      end else begin
        verd = 1'b1;
        if (magic_bad) begin
          st = STATUS_BAD_MAGIC;
        end else begin
          st = ({it.data_byte, crc_lo} == crc_acc) ? STATUS_OK : STATUS_BAD_CRC;
        end
      end
      // Buffer ended before the frame did; a short buffer outranks bad magic
      if (!verd && it.last_of_buffer) begin
        verd = 1'b1;
        if (p + 1 < MIN_BYTES) begin
          st = STATUS_TOO_SHORT;
        end else begin
          st = magic_bad ? STATUS_BAD_MAGIC : STATUS_TOO_SHORT;
        end
      end
      if (parse_pos != POS_MAX) begin
        parse_pos = parse_pos + 1'b1;
      end
      if (verd) begin
        frame_done = 1'b1;
      end
      if (pay || verd) begin
        r.out_byte       = pay ? it.data_byte : 8'h00;
        r.is_payload     = pay;
        r.is_verdict     = verd;
        r.status         = verd ? st : STATUS_OK;
        r.frame_msg_id   = hdr_id;
        r.frame_seq      = hdr_seq;
        r.payload_length = hdr_len;
        pending_results = {pending_results, r};
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input frame_out_t got);
    frame_out_t want;
    if (pending_results.size() == 0) begin
      $error("result %h arrived with nothing pending", got);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      check_field("out_byte", want.out_byte, got.out_byte);
      check_field("is_payload", want.is_payload, got.is_payload);
      check_field("is_verdict", want.is_verdict, got.is_verdict);
      check_field("status", want.status, got.status);
      check_field("frame_msg_id", want.frame_msg_id, got.frame_msg_id);
      check_field("frame_seq", want.frame_seq, got.frame_seq);
      check_field("payload_length", want.payload_length, got.payload_length);
    end
  endtask

  // Predict on every accepted item, then check every accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) begin
        predict_byte(item);
      end
      if (result_valid && result_ready) begin
        check_result(result);
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    result_ready <= steady ? 1'b1 : ($urandom_range(99) >= 35);
  end

  // Give up once nothing has moved for too long
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item, idling first at random, and hold it until accepted
  task automatic send_byte(input logic [7:0] d, input logic first, input logic last);
    if (!steady && $urandom_range(99) < 35) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 35);
    end
    item       <= '{data_byte: d, first_of_buffer: first, last_of_buffer: last};
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    items_sent++;
  endtask

  task automatic send_buffer(input octet_q_t frame_bytes, input logic mark_first,
                             input logic mark_last);
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i], mark_first && i == 0,
                mark_last && i == frame_bytes.size() - 1);
    end
  endtask

  // Header, random payload and little-endian CRC, optionally with one bit flipped
  function automatic octet_q_t build_frame(input logic [7:0] mg, id, len, seq,
                                           input logic corrupt);
    octet_q_t    fr;
    logic [15:0] c;
    fr = {fr, mg};
    fr = {fr, id};
    fr = {fr, len};
    fr = {fr, seq};
    repeat (len) fr = {fr, 8'($urandom)};
    c = CRC_INIT;
    foreach (fr[i]) begin
      c = crc_fold(c, fr[i]);
    end
    if (corrupt) begin
      c ^= 16'(1) << $urandom_range(15);
    end
    fr = {fr, c[7:0]};
    fr = {fr, c[15:8]};
    return fr;
  endfunction

  // Hold off input until every result is in and the pipeline is empty
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the magic byte, then read it back
  task automatic write_magic(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAGIC_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    magic_cfg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== PDATA_W'(value)) begin
      $error("magic_value: expected %0h, got %0h", value, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Good frame with no first mark straight after reset, magic at its reset value
  task automatic test_no_first_mark();
    send_buffer(build_frame(8'h00, 8'hFF, 8'h00, 8'h00, 1'b0), 1'b0, 1'b1);
  endtask

  // One-byte buffer with a wrong magic: too short wins
  task automatic test_short_buffer();
    send_byte(8'hFF, 1'b1, 1'b1);
  endtask

  // Wrong magic: payload withheld, verdict at the CRC, trailing byte dropped
  task automatic test_bad_magic_trailing();
    octet_q_t fr;
    fr = build_frame(8'h5A, 8'h01, 8'h01, 8'hFE, 1'b0);
    fr = {fr, 8'h00};
    send_buffer(fr, 1'b1, 1'b1);
  endtask

  // Abandon a frame mid-header, then send one with a broken CRC
  task automatic test_dropped_frame_bad_crc();
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h7E, 1'b0, 1'b0);
    send_buffer(build_frame(8'h00, 8'h80, 8'h00, 8'h7F, 1'b1), 1'b1, 1'b1);
  endtask

  // Payload byte that also ends the buffer carries both payload and verdict
  task automatic test_payload_ends_buffer();
    octet_q_t fr;
    fr    = build_frame(8'h00, 8'h42, 8'h03, 8'hFF, 1'b0);
    fr[4] = 8'h00;
    fr[5] = 8'hFF;
    while (fr.size() > MIN_BYTES) void'(fr.pop_back());
    send_buffer(fr, 1'b1, 1'b1);
  endtask

  task automatic test_longest_payload();
    send_buffer(build_frame(magic_cfg, 8'hA5, 8'hFF, 8'h5A, 1'b0), 1'b1, 1'b1);
  endtask

  // Mostly well-formed frames with random content, some broken, some noise
  task automatic send_random_buffer();
    octet_q_t   fr;
    int         kind;
    int         len;
    int         cut;
    logic       wrong_magic;
    logic [7:0] mg;
    kind        = $urandom_range(99);
    len         = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
    wrong_magic = (kind >= 60 && kind < 70) || (kind >= 70 && $urandom_range(2) == 0);
    mg          = wrong_magic ? magic_cfg ^ 8'($urandom_range(1, 255)) : magic_cfg;
    fr          = build_frame(mg, 8'($urandom), 8'(len), 8'($urandom),
                              kind >= 50 && kind < 60);
    if (kind < 50) begin
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) fr = {fr, 8'($urandom)};
      end
      send_buffer(fr, 1'b1, 1'b1);
    end else if (kind < 70) begin
      send_buffer(fr, 1'b1, 1'b1);
    end else if (kind < 88) begin
      // Cut short: ended by a last mark, or left open for the next buffer
      cut = $urandom_range(1, fr.size() - 1);
      while (fr.size() > cut) void'(fr.pop_back());
      send_buffer(fr, 1'b1, kind < 80);
    end else begin
      repeat ($urandom_range(1, 6)) begin
        send_byte(8'($urandom), $urandom_range(3) == 0, $urandom_range(3) == 0);
      end
    end
  endtask

  task automatic test_random_frames();
    int target;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      steady = (ph == 1);
      case (ph)
        0: begin
          write_magic(8'hFF);
        end
        2: begin
          write_magic(8'h00);
        end
        default: begin
          write_magic(8'($urandom_range(1, 254)));
        end
      endcase
      target = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < target) begin
        send_random_buffer();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    item_valid   = 1'b0;
    item         = '0;
    result_ready = 1'b0;
    steady       = 1'b0;
    mismatches   = 0;
    items_sent   = 0;
    quiet_cycles = 0;
    magic_cfg    = MAGIC_RESET;
    clear_frame();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_no_first_mark();
    test_short_buffer();
    test_bad_magic_trailing();
    test_dropped_frame_bad_crc();
    test_payload_ends_buffer();
    test_longest_payload();
    test_random_frames();
    wait_drained();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
